// File: design/tksd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_pkg: terminal key decoder definitions
// Parse phases, key codes, byte constants and the '~' key lookup.
// ----------------------------------------------------------------------------
package tksd_pkg;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_ESC   = 7'b0000010,
        PH_CSI0  = 7'b0000100,
        PH_LINUX = 7'b0001000,
        PH_SS3   = 7'b0010000,
        PH_PARAM = 7'b0100000,
        PH_DRAIN = 7'b1000000
    } phase_t;

    // Key codes; F2..F12 follow F1 in order
    localparam logic [4:0] KC_CHAR    = 5'd0;
    localparam logic [4:0] KC_TAB     = 5'd1;
    localparam logic [4:0] KC_ENTER   = 5'd2;
    localparam logic [4:0] KC_BS      = 5'd3;
    localparam logic [4:0] KC_ESC     = 5'd4;
    localparam logic [4:0] KC_UP      = 5'd5;
    localparam logic [4:0] KC_DOWN    = 5'd6;
    localparam logic [4:0] KC_RIGHT   = 5'd7;
    localparam logic [4:0] KC_LEFT    = 5'd8;
    localparam logic [4:0] KC_HOME    = 5'd9;
    localparam logic [4:0] KC_END     = 5'd10;
    localparam logic [4:0] KC_BACKTAB = 5'd11;
    localparam logic [4:0] KC_INSERT  = 5'd12;
    localparam logic [4:0] KC_DELETE  = 5'd13;
    localparam logic [4:0] KC_PGUP    = 5'd14;
    localparam logic [4:0] KC_PGDN    = 5'd15;
    localparam logic [4:0] KC_F1      = 5'd16;

    // Byte values
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Leading number limits
    localparam logic [6:0] NUM_MAX   = 7'd99;
    localparam logic [6:0] TILDE_MAX = 7'd24;

    // Decoded key with a found flag
    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } key_hit_t;

    // Map the leading number of a '~' sequence to a key
    function automatic key_hit_t tilde_lookup(input logic [4:0] num);
        key_hit_t k;
        k.hit  = 1'b1;
        k.code = KC_CHAR;
        case (num)
            5'd1:    k.code = KC_HOME;
            5'd2:    k.code = KC_INSERT;
            5'd3:    k.code = KC_DELETE;
            5'd4:    k.code = KC_END;
            5'd5:    k.code = KC_PGUP;
            5'd6:    k.code = KC_PGDN;
            5'd7:    k.code = KC_HOME;
            5'd8:    k.code = KC_END;
            5'd11:   k.code = KC_F1;
            5'd12:   k.code = KC_F1 + 5'd1;
            5'd13:   k.code = KC_F1 + 5'd2;
            5'd14:   k.code = KC_F1 + 5'd3;
            5'd15:   k.code = KC_F1 + 5'd4;
            5'd17:   k.code = KC_F1 + 5'd5;
            5'd18:   k.code = KC_F1 + 5'd6;
            5'd19:   k.code = KC_F1 + 5'd7;
            5'd20:   k.code = KC_F1 + 5'd8;
            5'd21:   k.code = KC_F1 + 5'd9;
            5'd23:   k.code = KC_F1 + 5'd10;
            5'd24:   k.code = KC_F1 + 5'd11;
            default: k.hit  = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// File: design/tksd_term_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_term_if: terminal event channel
// One transaction is a received byte or a wait-expired event.
// ----------------------------------------------------------------------------
interface tksd_term_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// File: design/tksd_key_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksd_key_if: key event channel
// One transaction is a decoded key code with its character byte.
// ----------------------------------------------------------------------------
interface tksd_key_if;
    logic       valid;
    logic       ready;
    logic [4:0] key_code;
    logic [7:0] char_byte;

    modport source (output valid, output key_code, output char_byte, input ready);
    modport sink   (input valid, input key_code, input char_byte, output ready);
endinterface

// File: design/terminal_key_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder: terminal input to key events
// Parses plain bytes, ESC, SS3, Linux console and CSI sequences into keys.
//
//   channel | port | direction | payload
//   --------+------+-----------+---------------------------
//   events  | term | sink      | command, data_byte
//   keys    | key  | source    | key_code, char_byte
//
// One event is taken every cycle that term.ready is high; its key, if any,
// appears in the output register on the next cycle; parse state updates in
// the same cycle. term.ready drops only while a key waits in the output
// register and key.ready is low. Reset idles the parser and empties the output.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder #(
    parameter int PARAM_LIMIT = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    tksd_term_if.sink   term,
    tksd_key_if.source  key
);

    localparam int LEN_W = $clog2(PARAM_LIMIT + 1);

    tksd_pkg::phase_t phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next, len_inc;
    logic [6:0]       num_reg, num_next, num_sat;
    logic [9:0]       num_prod;
    logic             closed_reg, closed_next;
    logic             out_valid_reg;
    logic [4:0]       code_reg;
    logic [7:0]       char_reg;

    logic             accept;
    logic             run_csi;
    logic [7:0]       b;
    logic             is_digit, is_semi, is_final;
    tksd_pkg::key_hit_t final_key;
    logic             hit;
    logic [4:0]       code;
    logic [7:0]       char_val;

    assign b          = term.data_byte;
    assign term.ready = !out_valid_reg || key.ready;
    assign accept     = term.valid && term.ready;

    // Classify the byte for the CSI parameter area
    always_comb
    begin
        is_digit = b inside {[tksd_pkg::CH_0:tksd_pkg::CH_9]};
        is_semi  = (b == tksd_pkg::CH_SEMI);
        is_final = (b inside {[tksd_pkg::CH_A:tksd_pkg::CH_Z],
                              [tksd_pkg::CH_LA:tksd_pkg::CH_LZ]})
                   || (b == tksd_pkg::CH_TILDE);
    end

    // Accumulate the leading number, saturating at the limit
    always_comb
    begin
        num_prod = {num_reg, 3'b000} + {2'b00, num_reg, 1'b0}
                   + {6'd0, 4'(b - tksd_pkg::CH_0)};
        num_sat  = (num_prod > 10'(tksd_pkg::NUM_MAX)) ? tksd_pkg::NUM_MAX
                                                        : num_prod[6:0];
        len_inc  = len_reg + 1'b1;
    end

    // Look up the key for a CSI final byte
    always_comb
    begin
        final_key.hit  = 1'b1;
        final_key.code = tksd_pkg::KC_CHAR;
        if (len_reg == '0)
        begin
            case (b)
                tksd_pkg::CH_A: final_key.code = tksd_pkg::KC_UP;
                tksd_pkg::CH_B: final_key.code = tksd_pkg::KC_DOWN;
                tksd_pkg::CH_C: final_key.code = tksd_pkg::KC_RIGHT;
                tksd_pkg::CH_D: final_key.code = tksd_pkg::KC_LEFT;
                tksd_pkg::CH_H: final_key.code = tksd_pkg::KC_HOME;
                tksd_pkg::CH_F: final_key.code = tksd_pkg::KC_END;
                tksd_pkg::CH_Z: final_key.code = tksd_pkg::KC_BACKTAB;
                default:        final_key.hit  = 1'b0;
            endcase
        end
        else if (b == tksd_pkg::CH_TILDE && num_reg <= tksd_pkg::TILDE_MAX)
        begin
            final_key = tksd_pkg::tilde_lookup(num_reg[4:0]);
        end
        else
        begin
            final_key.hit = 1'b0;
        end
    end

    // Advance the parser for one event
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        num_next    = num_reg;
        closed_next = closed_reg;
        hit         = 1'b0;
        code        = tksd_pkg::KC_CHAR;
        char_val    = 8'd0;
        run_csi     = 1'b0;

        if (term.command)
        begin
            // Wait expired: a pending ESC prefix becomes the escape key
            phase_next = tksd_pkg::PH_IDLE;
            if (phase_reg == tksd_pkg::PH_ESC || phase_reg == tksd_pkg::PH_CSI0 ||
                phase_reg == tksd_pkg::PH_LINUX || phase_reg == tksd_pkg::PH_SS3)
            begin
                hit  = 1'b1;
                code = tksd_pkg::KC_ESC;
            end
        end
        else
        begin
            case (phase_reg)
                tksd_pkg::PH_ESC:
                begin
                    if (b == tksd_pkg::CH_LBRK)
                    begin
                        phase_next  = tksd_pkg::PH_CSI0;
                        len_next    = '0;
                        num_next    = 7'd0;
                        closed_next = 1'b0;
                    end
                    else if (b == tksd_pkg::CH_O)
                    begin
                        phase_next = tksd_pkg::PH_SS3;
                    end
                    else
                    begin
                        phase_next = tksd_pkg::PH_IDLE;
                        hit        = 1'b1;
                        code       = tksd_pkg::KC_ESC;
                    end
                end
                tksd_pkg::PH_CSI0:
                begin
                    if (b == tksd_pkg::CH_LBRK)
                        phase_next = tksd_pkg::PH_LINUX;
                    else
                        run_csi = 1'b1;
                end
                tksd_pkg::PH_PARAM:
                begin
                    run_csi = 1'b1;
                end
                tksd_pkg::PH_LINUX:
                begin
                    phase_next = tksd_pkg::PH_IDLE;
                    if (b inside {[tksd_pkg::CH_A:tksd_pkg::CH_E]})
                    begin
                        hit  = 1'b1;
                        code = tksd_pkg::KC_F1 + 5'(b - tksd_pkg::CH_A);
                    end
                end
                tksd_pkg::PH_SS3:
                begin
                    phase_next = tksd_pkg::PH_IDLE;
                    if (b inside {[tksd_pkg::CH_P:tksd_pkg::CH_S]})
                    begin
                        hit  = 1'b1;
                        code = tksd_pkg::KC_F1 + 5'(b - tksd_pkg::CH_P);
                    end
                end
                tksd_pkg::PH_DRAIN:
                begin
                    phase_next = tksd_pkg::PH_IDLE;
                end
                default:
                begin
                    // Idle, and any unused phase code
                    phase_next = tksd_pkg::PH_IDLE;
                    hit        = 1'b1;
                    if (b == tksd_pkg::CH_ESC)
                    begin
                        phase_next = tksd_pkg::PH_ESC;
                        hit        = 1'b0;
                    end
                    else if (b == tksd_pkg::CH_TAB)
                    begin
                        code     = tksd_pkg::KC_TAB;
                        char_val = b;
                    end
                    else if (b == tksd_pkg::CH_CR || b == tksd_pkg::CH_LF)
                    begin
                        code     = tksd_pkg::KC_ENTER;
                        char_val = tksd_pkg::CH_CR;
                    end
                    else if (b == tksd_pkg::CH_DEL)
                    begin
                        code     = tksd_pkg::KC_BS;
                        char_val = tksd_pkg::CH_DEL;
                    end
                    else
                    begin
                        code     = tksd_pkg::KC_CHAR;
                        char_val = b;
                    end
                end
            endcase

            // Take one byte of the CSI parameter area
            if (run_csi)
            begin
                if (is_digit || is_semi)
                begin
                    if (is_semi)
                        closed_next = 1'b1;
                    else if (!closed_reg)
                        num_next = num_sat;
                    len_next   = len_inc;
                    phase_next = (len_inc >= LEN_W'(PARAM_LIMIT)) ? tksd_pkg::PH_DRAIN
                                                                   : tksd_pkg::PH_PARAM;
                end
                else if (is_final)
                begin
                    phase_next = tksd_pkg::PH_IDLE;
                    hit        = final_key.hit;
                    code       = final_key.code;
                end
                else
                begin
                    phase_next = tksd_pkg::PH_PARAM;
                end
            end
        end
    end

    // Hold parse state; update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tksd_pkg::PH_IDLE;
            len_reg    <= '0;
            num_reg    <= 7'd0;
            closed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            num_reg    <= num_next;
            closed_reg <= closed_next;
        end
    end

    // Output register: load a key, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= hit;
        else if (key.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            code_reg <= code;
            char_reg <= char_val;
        end
    end

    assign key.valid     = out_valid_reg;
    assign key.key_code  = code_reg;
    assign key.char_byte = char_reg;

endmodule
